/* sv/mfns_pkg.sv */
// shared types, constants and the corner distance function for the first node selector
`default_nettype none
package mfns_pkg;

  localparam int PE_COUNT   = 64;
  localparam int MESH_WIDTH = 8;

  localparam int IDX_W  = 6;
  localparam int FREE_W = 4;
  localparam int DIST_W = 8;
  localparam int PROD_W = 2 * (IDX_W + 1) + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [IDX_W:0]    PE_LIMIT = (IDX_W + 1)'(PE_COUNT);

  localparam logic MODE_CONA       = 1'b0;
  localparam logic MODE_FIRST_FREE = 1'b1;

  typedef struct packed {
    logic              last_pe;
    logic [FREE_W-1:0] free_neighbors;
    logic              pe_busy;
    logic [IDX_W-1:0]  pe_index;
  } pe_rec_t;

  typedef struct packed {
    logic             node_found;
    logic [IDX_W-1:0] chosen_node;
  } sel_result_t;

  function automatic logic [DIST_W-1:0] corner_dist(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0]    row;
    logic [IDX_W:0]    col;
    logic [PROD_W-1:0] d;
    row = (IDX_W + 1)'(idx / MESH_WIDTH) + (IDX_W + 1)'(1);
    col = (IDX_W + 1)'(idx % MESH_WIDTH) + (IDX_W + 1)'(1);
    d   = PROD_W'(row * row) + PROD_W'(col * col);
    if (d > PROD_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return d[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/mesh_first_node_selector_unit.sv */
// top level of the mesh first node selector
// usage:
//   records stream in on s_axis (one pe record per request, tlast on the
//   final record of a scan); one result per scan leaves on m_axis.
//   cfg_valid/cfg_data write select_mode (0 cona, 1 first free); write it
//   only while no scan is in flight. cfg_ready is always high.
// timing:
//   a record is taken into an input register and judged against the running
//   best while it sits there; on the last record the result lands in the
//   output register and m_tvalid rises.
//   one record per cycle is accepted while s_tready is high, set by the single compare stage.
// reset:
//   rst clears the mode to cona, the running best and both valid flags.
// stall:
//   while a result waits on m_tready the block keeps taking records; only a
//   second last record stalls in the input register, and s_tready drops
//   until the waiting result is taken.
`default_nettype none
module mesh_first_node_selector_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // pe_index[5:0], pe_busy[6], free_neighbors[10:7], zero
  input  wire        s_tlast,   // last_pe
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // chosen_node[5:0], node_found[6], zero
);
  import mfns_pkg::*;

  logic        select_mode;
  logic        in_valid;
  pe_rec_t     in_rec;
  logic        advance;
  logic        out_free;
  sel_result_t res;
  sel_result_t out_res;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && (!in_rec.last_pe || out_free);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= MODE_CONA;
    end else if (cfg_valid && cfg_ready) begin
      select_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_rec.pe_index       <= s_tdata[5:0];
      in_rec.pe_busy        <= s_tdata[6];
      in_rec.free_neighbors <= s_tdata[10:7];
      in_rec.last_pe        <= s_tlast;
    end
  end

  mfns_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .mode (select_mode),
    .rec  (in_rec),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_rec.last_pe) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_rec.last_pe) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.node_found, out_res.chosen_node};

`ifndef NO_ASSERTIONS
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");
  a_no_node_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[6]) |-> (m_tdata[5:0] == 6'd0))
    else $error("nonzero node without an idle pe");
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && in_valid && in_rec.last_pe))
    else $error("input stalled without a pending result");
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_rec.last_pe) |=> m_tvalid)
    else $error("last record produced no result");
`endif

endmodule
`default_nettype wire

/* sv/mfns_tracker.sv */
// running best-candidate state and the per-record compare and update
`default_nettype none
module mfns_tracker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  mode,
  input  mfns_pkg::pe_rec_t    rec,
  output mfns_pkg::sel_result_t res
);
  import mfns_pkg::*;

  logic [FREE_W-1:0] best_free_count, best_free_count_next;
  logic [DIST_W-1:0] best_corner_distance, best_corner_distance_next;
  logic [IDX_W-1:0]  best_node, best_node_next;
  logic              any_idle_seen, any_idle_seen_next;
  logic              idle;
  logic              take;
  logic [DIST_W-1:0] pe_dist;

  assign pe_dist = corner_dist(rec.pe_index);
  assign idle = !rec.pe_busy && (rec.pe_index != '0) && ({1'b0, rec.pe_index} < PE_LIMIT);

  always_comb begin
    take = 1'b0;
    if (idle) begin
      if (mode == MODE_CONA) begin
        take = !any_idle_seen
            || (rec.free_neighbors > best_free_count)
            || ((rec.free_neighbors == best_free_count) && (pe_dist < best_corner_distance));
      end else begin
        take = !any_idle_seen || (rec.pe_index < best_node);
      end
    end
  end

  always_comb begin
    best_free_count_next      = best_free_count;
    best_corner_distance_next = best_corner_distance;
    best_node_next            = best_node;
    any_idle_seen_next        = any_idle_seen || idle;
    if (take) begin
      best_node_next = rec.pe_index;
      if (mode == MODE_CONA) begin
        best_free_count_next      = rec.free_neighbors;
        best_corner_distance_next = pe_dist;
      end
    end
  end

  assign res.node_found  = any_idle_seen_next;
  assign res.chosen_node = any_idle_seen_next ? best_node_next : '0;

  always_ff @(posedge clk) begin
    if (rst || (en && rec.last_pe)) begin
      best_free_count      <= '0;
      best_corner_distance <= DIST_MAX;
      best_node            <= '0;
      any_idle_seen        <= 1'b0;
    end else if (en) begin
      best_free_count      <= best_free_count_next;
      best_corner_distance <= best_corner_distance_next;
      best_node            <= best_node_next;
      any_idle_seen        <= any_idle_seen_next;
    end
  end

endmodule
`default_nettype wire
